// ----- hdl/gwwgl_pkg.sv -----
// Package for the greedy word-wrap glyph layout block.
// Holds sizes, character codes, register indexes, the sequencer states and the
// structs shared by the top level and its output stage. No dependencies.
package gwwgl_pkg;

  // Sizing of the group buffers and the line counter
  localparam int WORD_MAX        = 32;
  localparam int SPACE_MAX       = 32;
  localparam int LINE_INDEX_BITS = 10;

  // Fixed field widths
  localparam int CODE_W     = 21;
  localparam int ADV_W      = 12;
  localparam int GLYPH_W    = 16;
  localparam int X_W        = 16;
  localparam int Y_W        = 24;
  localparam int HEIGHT_W   = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Derived sizes
  localparam int WCNT_W  = $clog2(WORD_MAX + 1);
  localparam int SCNT_W  = $clog2(SPACE_MAX + 1);
  localparam int IDX_W   = (WCNT_W > SCNT_W) ? WCNT_W : SCNT_W;
  localparam int WADDR_W = $clog2(WORD_MAX);
  localparam int SADDR_W = $clog2(SPACE_MAX);
  localparam int ADV_MAX = (1 << ADV_W) - 1;
  localparam int WWID_W  = $clog2(WORD_MAX * ADV_MAX + 1);
  localparam int SWID_W  = $clog2(SPACE_MAX * ADV_MAX + 1);
  localparam int OPND_W  = (WWID_W > SWID_W) ? WWID_W : SWID_W;
  localparam int SUM_W   = ((OPND_W > X_W) ? OPND_W : X_W) + 1;
  localparam int ENTRY_W = GLYPH_W + ADV_W;
  localparam int PROD_W  = LINE_INDEX_BITS + HEIGHT_W;
  localparam int YCMP_W  = (PROD_W > Y_W) ? PROD_W : Y_W;

  localparam logic [X_W-1:0]             X_MAX    = {X_W{1'b1}};
  localparam logic [Y_W-1:0]             Y_MAX    = {Y_W{1'b1}};
  localparam logic [LINE_INDEX_BITS-1:0] LIDX_MAX = {LINE_INDEX_BITS{1'b1}};

  // Character codes
  localparam logic [CODE_W-1:0] CH_NEWLINE = CODE_W'(10);
  localparam logic [CODE_W-1:0] CH_SPACE   = CODE_W'(32);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = CFG_IDX_W'(2);

  // Reset values of the configuration registers
  localparam logic [X_W-1:0]      LINE_LENGTH_RST = X_W'(65535);
  localparam logic [HEIGHT_W-1:0] LINE_HEIGHT_RST = HEIGHT_W'(1024);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SINGLE,
    ST_FSTART,
    ST_WRD,
    ST_WCHK,
    ST_WNL,
    ST_WPUT,
    ST_STEST,
    ST_SRD,
    ST_SPUT,
    ST_POST,
    ST_STORE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
  } place_t;

  typedef struct packed {
    logic push;
    logic fin;
  } out_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic fin_ok;
  } out_sts_t;

endpackage

// ----- hdl/greedy_word_wrap_glyph_layout.sv -----
// Greedy word-wrap glyph layout: top level with sequencer, group buffers and
// the shared add/compare unit. Depends on gwwgl_pkg and gwwgl_out_stage.
//
// Usage
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tlast, one character
//   each; s_tlast marks end of text, which flushes the buffered word and
//   spaces and returns the line position to the origin. Placements leave on
//   m_tvalid/m_tready/m_tdata/m_tlast; m_tlast is set on the final placement
//   that an input item causes. Registers are written via cfg_valid, cfg_ready,
//   cfg_index, cfg_data while the block is idle, a user duty it does not check.
// Timing
//   One item at a time. A group flush places the word glyphs, with an extra
//   state where one breaks the line, then the placed spaces, all through one
//   shared adder/comparator. The last placement of an item leaves the output
//   stage, marked last, once the item finishes.
// Reset and stalls
//   rst (synchronous) clears the line position, both buffers and the output
//   stage, and loads the register defaults. When the receiver holds m_tready
//   low, the sequencer waits at its next placement; nothing is dropped.
module greedy_word_wrap_glyph_layout (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: char_code [20:0], advance [32:21], glyph_handle [48:33], zero above
  input  logic [gwwgl_pkg::IN_TDATA_W-1:0]     s_tdata,
  // s_tlast: end_of_text
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: out_glyph [15:0], pos_x [31:16], pos_y [55:32]
  output logic [gwwgl_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tlast: last
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gwwgl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gwwgl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gwwgl_pkg::state_t state, state_next;

  // Registers
  logic                                   wrap_mode;
  logic [gwwgl_pkg::X_W-1:0]              line_length;
  logic [gwwgl_pkg::HEIGHT_W-1:0]         line_height;

  // Line state and group bookkeeping
  logic [gwwgl_pkg::X_W-1:0]              line_x;
  logic [gwwgl_pkg::LINE_INDEX_BITS-1:0]  line_index;
  logic [gwwgl_pkg::Y_W-1:0]              y_cur;
  logic [gwwgl_pkg::WCNT_W-1:0]           word_count;
  logic [gwwgl_pkg::WWID_W-1:0]           word_width;
  logic [gwwgl_pkg::SCNT_W-1:0]           space_count;
  logic [gwwgl_pkg::SWID_W-1:0]           space_width;
  logic                                   brk;
  logic [gwwgl_pkg::IDX_W-1:0]            idx;
  logic [gwwgl_pkg::IDX_W-1:0]            idx_inc;

  // Item held while it is worked on
  logic                                   eot_q;
  logic                                   nl_q;
  logic                                   sp_q;
  logic [gwwgl_pkg::ADV_W-1:0]            adv_q;
  logic [gwwgl_pkg::GLYPH_W-1:0]          handle_q;

  // Group buffers
  logic [gwwgl_pkg::ENTRY_W-1:0]          word_mem  [gwwgl_pkg::WORD_MAX];
  logic [gwwgl_pkg::ENTRY_W-1:0]          space_mem [gwwgl_pkg::SPACE_MAX];
  logic [gwwgl_pkg::ENTRY_W-1:0]          word_q;
  logic [gwwgl_pkg::ENTRY_W-1:0]          space_q;
  logic                                   word_we;
  logic                                   space_we;
  logic [gwwgl_pkg::WADDR_W-1:0]          word_waddr;
  logic [gwwgl_pkg::SADDR_W-1:0]          space_waddr;

  // Shared adder / comparator
  logic [gwwgl_pkg::OPND_W-1:0]           opnd;
  logic [gwwgl_pkg::SUM_W-1:0]            sum;
  logic                                   over;
  logic [gwwgl_pkg::X_W-1:0]              sat_x;

  // Line pitch multiplier
  logic [gwwgl_pkg::PROD_W-1:0]           prod;
  logic [gwwgl_pkg::YCMP_W-1:0]           prod_ext;

  gwwgl_pkg::out_ctl_t                    octl;
  gwwgl_pkg::out_sts_t                    osts;
  gwwgl_pkg::place_t                      place;

  logic                                   word_full;
  logic                                   space_full;
  logic                                   word_done;
  logic                                   space_done;
  logic                                   open_word;
  logic                                   open_space;

  assign cfg_ready  = !rst;
  assign idx_inc    = idx + 1'b1;
  assign word_full  = word_count >= gwwgl_pkg::WCNT_W'(gwwgl_pkg::WORD_MAX);
  assign space_full = space_count >= gwwgl_pkg::SCNT_W'(gwwgl_pkg::SPACE_MAX);
  assign word_done  = idx_inc == gwwgl_pkg::IDX_W'(word_count);
  assign space_done = idx_inc == gwwgl_pkg::IDX_W'(space_count);
  // the held character opens the next group after a flush
  assign open_word  = !eot_q && !nl_q && !sp_q;
  assign open_space = !eot_q && !nl_q && sp_q;

  // Operand select for the shared unit: group widths for the fit tests,
  // one glyph advance for break tests and x advance.
  always_comb begin
    unique case (state)
      gwwgl_pkg::ST_FSTART: opnd = gwwgl_pkg::OPND_W'(word_width);
      gwwgl_pkg::ST_STEST:  opnd = gwwgl_pkg::OPND_W'(space_width);
      gwwgl_pkg::ST_WCHK,
      gwwgl_pkg::ST_WNL,
      gwwgl_pkg::ST_WPUT:   opnd = gwwgl_pkg::OPND_W'(word_q[gwwgl_pkg::ADV_W-1:0]);
      gwwgl_pkg::ST_SPUT:   opnd = gwwgl_pkg::OPND_W'(space_q[gwwgl_pkg::ADV_W-1:0]);
      gwwgl_pkg::ST_SINGLE: opnd = gwwgl_pkg::OPND_W'(adv_q);
      default:              opnd = '0;
    endcase
  end

  assign sum   = gwwgl_pkg::SUM_W'(line_x) + gwwgl_pkg::SUM_W'(opnd);
  assign over  = sum > gwwgl_pkg::SUM_W'(line_length);
  assign sat_x = (sum > gwwgl_pkg::SUM_W'(gwwgl_pkg::X_MAX)) ? gwwgl_pkg::X_MAX
                                                            : sum[gwwgl_pkg::X_W-1:0];

  // y follows line index in the cycle after; the sequencer leaves a gap state
  // after every line break before the next placement.
  assign prod     = gwwgl_pkg::PROD_W'(line_index) * gwwgl_pkg::PROD_W'(line_height);
  assign prod_ext = gwwgl_pkg::YCMP_W'(prod);

  always_ff @(posedge clk) begin
    if (prod_ext > gwwgl_pkg::YCMP_W'(gwwgl_pkg::Y_MAX)) begin
      y_cur <= gwwgl_pkg::Y_MAX;
    end else begin
      y_cur <= prod_ext[gwwgl_pkg::Y_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gwwgl_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = gwwgl_pkg::ST_DISP;
      end
      gwwgl_pkg::ST_DISP: begin
        if (eot_q) begin
          state_next = gwwgl_pkg::ST_FSTART;
        end else if (!wrap_mode) begin
          state_next = gwwgl_pkg::ST_SINGLE;
        end else if (nl_q) begin
          state_next = gwwgl_pkg::ST_FSTART;
        end else if (sp_q) begin
          state_next = space_full ? gwwgl_pkg::ST_FSTART : gwwgl_pkg::ST_STORE;
        end else if (space_count != '0 || word_full) begin
          state_next = gwwgl_pkg::ST_FSTART;
        end else begin
          state_next = gwwgl_pkg::ST_STORE;
        end
      end
      gwwgl_pkg::ST_SINGLE: begin
        if (osts.push_ok) state_next = gwwgl_pkg::ST_FIN;
      end
      gwwgl_pkg::ST_FSTART: begin
        state_next = (word_count != '0) ? gwwgl_pkg::ST_WRD : gwwgl_pkg::ST_STEST;
      end
      gwwgl_pkg::ST_WRD:  state_next = gwwgl_pkg::ST_WCHK;
      gwwgl_pkg::ST_WCHK: begin
        state_next = (brk && over) ? gwwgl_pkg::ST_WNL : gwwgl_pkg::ST_WPUT;
      end
      gwwgl_pkg::ST_WNL:  state_next = gwwgl_pkg::ST_WPUT;
      gwwgl_pkg::ST_WPUT: begin
        if (osts.push_ok) begin
          state_next = word_done ? gwwgl_pkg::ST_STEST : gwwgl_pkg::ST_WRD;
        end
      end
      gwwgl_pkg::ST_STEST: begin
        state_next = (!over && space_count != '0) ? gwwgl_pkg::ST_SRD
                                                  : gwwgl_pkg::ST_POST;
      end
      gwwgl_pkg::ST_SRD:  state_next = gwwgl_pkg::ST_SPUT;
      gwwgl_pkg::ST_SPUT: begin
        if (osts.push_ok) begin
          state_next = space_done ? gwwgl_pkg::ST_POST : gwwgl_pkg::ST_SRD;
        end
      end
      gwwgl_pkg::ST_POST:  state_next = gwwgl_pkg::ST_FIN;
      gwwgl_pkg::ST_STORE: state_next = gwwgl_pkg::ST_FIN;
      gwwgl_pkg::ST_FIN: begin
        if (osts.fin_ok) state_next = gwwgl_pkg::ST_IDLE;
      end
      default: state_next = gwwgl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready    = 1'b0;
    octl        = '0;
    place.glyph = word_q[gwwgl_pkg::ENTRY_W-1:gwwgl_pkg::ADV_W];
    place.x     = line_x;
    place.y     = y_cur;
    word_we     = 1'b0;
    space_we    = 1'b0;
    word_waddr  = word_count[gwwgl_pkg::WADDR_W-1:0];
    space_waddr = space_count[gwwgl_pkg::SADDR_W-1:0];
    unique case (state)
      gwwgl_pkg::ST_IDLE: s_tready = !rst;
      gwwgl_pkg::ST_SINGLE: begin
        octl.push   = 1'b1;
        place.glyph = handle_q;
        place.y     = '0;
      end
      gwwgl_pkg::ST_WPUT: octl.push = 1'b1;
      gwwgl_pkg::ST_SPUT: begin
        octl.push   = 1'b1;
        place.glyph = space_q[gwwgl_pkg::ENTRY_W-1:gwwgl_pkg::ADV_W];
      end
      gwwgl_pkg::ST_POST: begin
        // group was just emptied: the new character opens the next group
        word_waddr  = '0;
        space_waddr = '0;
        word_we     = open_word;
        space_we    = open_space;
      end
      gwwgl_pkg::ST_STORE: begin
        word_we  = !sp_q;
        space_we = sp_q;
      end
      gwwgl_pkg::ST_FIN: octl.fin = 1'b1;
      default: ;
    endcase
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gwwgl_pkg::ST_IDLE;
      wrap_mode   <= 1'b0;
      line_length <= gwwgl_pkg::LINE_LENGTH_RST;
      line_height <= gwwgl_pkg::LINE_HEIGHT_RST;
      line_x      <= '0;
      line_index  <= '0;
      word_count  <= '0;
      word_width  <= '0;
      space_count <= '0;
      space_width <= '0;
      brk         <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          gwwgl_pkg::REG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
          gwwgl_pkg::REG_LINE_LENGTH: line_length <= cfg_data;
          gwwgl_pkg::REG_LINE_HEIGHT: line_height <= cfg_data[gwwgl_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        gwwgl_pkg::ST_SINGLE: begin
          if (osts.push_ok) line_x <= sat_x;
        end
        gwwgl_pkg::ST_FSTART: begin
          idx <= '0;
          // per-glyph breaking only for a word longer than a whole line
          brk <= over && (gwwgl_pkg::OPND_W'(word_width) > gwwgl_pkg::OPND_W'(line_length));
          if (over && line_x != '0) begin
            line_x <= '0;
            if (line_index != gwwgl_pkg::LIDX_MAX) line_index <= line_index + 1'b1;
          end
        end
        gwwgl_pkg::ST_WCHK: begin
          if (brk && over) begin
            line_x <= '0;
            if (line_index != gwwgl_pkg::LIDX_MAX) line_index <= line_index + 1'b1;
          end
        end
        gwwgl_pkg::ST_WPUT,
        gwwgl_pkg::ST_SPUT: begin
          if (osts.push_ok) begin
            line_x <= sat_x;
            idx    <= idx_inc;
          end
        end
        gwwgl_pkg::ST_STEST: begin
          idx <= '0;
          // spaces that overflow are dropped and the line breaks instead
          if (over) begin
            line_x <= '0;
            if (line_index != gwwgl_pkg::LIDX_MAX) line_index <= line_index + 1'b1;
          end
        end
        gwwgl_pkg::ST_POST: begin
          if (eot_q) begin
            line_x     <= '0;
            line_index <= '0;
          end else if (nl_q) begin
            line_x <= '0;
            if (line_index != gwwgl_pkg::LIDX_MAX) line_index <= line_index + 1'b1;
          end
          if (open_space) begin
            space_count <= gwwgl_pkg::SCNT_W'(1);
            space_width <= gwwgl_pkg::SWID_W'(adv_q);
          end else begin
            space_count <= '0;
            space_width <= '0;
          end
          if (open_word) begin
            word_count <= gwwgl_pkg::WCNT_W'(1);
            word_width <= gwwgl_pkg::WWID_W'(adv_q);
          end else begin
            word_count <= '0;
            word_width <= '0;
          end
        end
        gwwgl_pkg::ST_STORE: begin
          if (sp_q) begin
            space_count <= space_count + 1'b1;
            space_width <= space_width + gwwgl_pkg::SWID_W'(adv_q);
          end else begin
            word_count <= word_count + 1'b1;
            word_width <= word_width + gwwgl_pkg::WWID_W'(adv_q);
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      eot_q    <= s_tlast;
      nl_q     <= s_tdata[gwwgl_pkg::CODE_W-1:0] == gwwgl_pkg::CH_NEWLINE;
      sp_q     <= s_tdata[gwwgl_pkg::CODE_W-1:0] == gwwgl_pkg::CH_SPACE;
      adv_q    <= s_tdata[gwwgl_pkg::CODE_W +: gwwgl_pkg::ADV_W];
      handle_q <= s_tdata[gwwgl_pkg::CODE_W + gwwgl_pkg::ADV_W +: gwwgl_pkg::GLYPH_W];
    end
  end

  // Group buffers: one write and one registered read each
  always_ff @(posedge clk) begin
    if (word_we) word_mem[word_waddr] <= {handle_q, adv_q};
    word_q <= word_mem[idx[gwwgl_pkg::WADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (space_we) space_mem[space_waddr] <= {handle_q, adv_q};
    space_q <= space_mem[idx[gwwgl_pkg::SADDR_W-1:0]];
  end

  gwwgl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (octl),
    .place    (place),
    .sts      (osts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Buffers never grow past their depth
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    word_count <= gwwgl_pkg::WCNT_W'(gwwgl_pkg::WORD_MAX))
    else $error("word buffer count beyond depth");

  a_space_count: assert property (@(posedge clk) disable iff (rst)
    space_count <= gwwgl_pkg::SCNT_W'(gwwgl_pkg::SPACE_MAX))
    else $error("space buffer count beyond depth");

  // One item at a time: no new item right after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // End of text returns the line position to the origin
  a_eot_home: assert property (@(posedge clk) disable iff (rst)
    state == gwwgl_pkg::ST_POST && eot_q |=> line_x == '0 && line_index == '0)
    else $error("line state not cleared at end of text");

endmodule

// ----- hdl/gwwgl_out_stage.sv -----
// Output stage of the glyph layout block: one pending placement and one
// output register, so the final placement of an item can be marked last.
// Depends on gwwgl_pkg.
module gwwgl_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  gwwgl_pkg::out_ctl_t                 ctl,
  input  gwwgl_pkg::place_t                   place,
  output gwwgl_pkg::out_sts_t                 sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: out_glyph [15:0], pos_x [31:16], pos_y [55:32]
  output logic [gwwgl_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                m_tlast
);

  logic               pend_valid;
  gwwgl_pkg::place_t  pend;
  logic               out_valid;
  gwwgl_pkg::place_t  out_q;
  logic               out_last;
  logic               out_free;
  logic               do_push;
  logic               do_fin;

  assign out_free    = !out_valid || m_tready;
  assign sts.push_ok = !pend_valid || out_free;
  assign sts.fin_ok  = !pend_valid || out_free;
  assign do_push     = ctl.push && sts.push_ok;
  assign do_fin      = ctl.fin && sts.fin_ok && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= (out_valid && !m_tready) || (do_push && pend_valid) || do_fin;
      if (do_push) begin
        pend_valid <= 1'b1;
      end
      if (do_fin) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Older placement moves out when a newer one arrives; the held one goes
  // out marked last when the item finishes.
  always_ff @(posedge clk) begin
    if (do_push) begin
      pend <= place;
      if (pend_valid) begin
        out_q    <= pend;
        out_last <= 1'b0;
      end
    end
    if (do_fin) begin
      out_q    <= pend;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_q.y, out_q.x, out_q.glyph};
  assign m_tlast  = out_last;

endmodule

// ----- sim/greedy_word_wrap_glyph_layout_tb.sv -----
// Self-checking bench for greedy_word_wrap_glyph_layout: directed table, then random text
// in both layout modes, checked placement by placement against a layout predictor.
// Depends on gwwgl_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module greedy_word_wrap_glyph_layout_tb;
  import gwwgl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 32;    // covers a flush with nothing to place
  localparam int END_WAIT    = 20000;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [ADV_W-1:0]   adv;
    logic [GLYPH_W-1:0] handle;
    logic               eot;
    bit                 typed;    // placement typed into the table, single-line only
    logic [X_W-1:0]     typed_x;
  } char_item_t;

  typedef struct {
    logic [GLYPH_W-1:0] glyph;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic               last;
  } placement_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    char_item_t            ch;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  greedy_word_wrap_glyph_layout u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Text waiting to be sent, placements still due, and the directed table
  char_item_t text_q[$];
  placement_t placements_due[$];
  placement_t step_out[$];
  dir_row_t   dir_tab[$];

  bit s_busy = 1'b0;        // an item is on the slave side, not yet taken
  int s_idle_pct = 14;
  int r_idle_pct = 78;
  int hold_off = 0;         // one long receiver hold-off, in cycles
  int held_total = 0;

  int errors = 0;
  int n_items = 0;
  int n_placed = 0;
  int cycle_n = 0;

  // Predictor copy of the registers and the layout state, at reset values
  bit                         cf_multi = 1'b0;
  logic [X_W-1:0]             cf_len = LINE_LENGTH_RST;
  logic [HEIGHT_W-1:0]        cf_height = LINE_HEIGHT_RST;
  logic [X_W-1:0]             lx = '0;
  logic [LINE_INDEX_BITS-1:0] lidx = '0;
  logic [ENTRY_W-1:0]         word_buf[$];
  logic [ENTRY_W-1:0]         space_buf[$];
  int unsigned                word_w = 0;
  int unsigned                space_w = 0;

  // Coverage tallies for the summary
  int deepest_line = 0;
  int x_clamps = 0;
  int word_full_flushes = 0;
  int space_full_flushes = 0;

  // ---------------------------------------------------------------------------
  // Clock, reset and the run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_n <= cycle_n + 1;

  initial begin
    wait (cycle_n >= CYCLE_LIMIT);
    $display("Run limit of %0d cycles reached, %0d placements still due",
             CYCLE_LIMIT, placements_due.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at placement %0d: %s", n_placed, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Layout predictor
  // ---------------------------------------------------------------------------
  function automatic void break_line();
    lx = '0;
    if (lidx != LIDX_MAX) lidx++;
    if (int'(lidx) > deepest_line) deepest_line = int'(lidx);
  endfunction

  function automatic logic [Y_W-1:0] line_y();
    int unsigned p;
    p = 32'(lidx) * 32'(cf_height);
    return (p > 32'(Y_MAX)) ? Y_MAX : Y_W'(p);
  endfunction

  // Emit a placement at the running x, then step x on with saturation
  function automatic void place_glyph(input logic [GLYPH_W-1:0] g, input logic [ADV_W-1:0] a);
    placement_t p;
    int unsigned s;
    p.glyph = g;
    p.x = lx;
    p.y = line_y();
    p.last = 1'b0;
    step_out.push_back(p);
    s = 32'(lx) + 32'(a);
    if (s > 32'(X_MAX)) begin
      lx = X_MAX;
      x_clamps++;
    end else begin
      lx = X_W'(s);
    end
  endfunction

  // Lay out the buffered word and its trailing spaces, then empty the buffers
  function automatic void flush_group();
    bit per_char;
    logic [ADV_W-1:0] a;
    per_char = 1'b0;
    if (32'(lx) + word_w > 32'(cf_len)) begin
      if (lx != '0) break_line();
      per_char = (word_w > 32'(cf_len));
    end
    foreach (word_buf[i]) begin
      a = word_buf[i][ADV_W-1:0];
      // A word wider than a whole line is broken glyph by glyph, even at x zero
      if (per_char && (32'(lx) + 32'(a) > 32'(cf_len))) break_line();
      place_glyph(word_buf[i][ENTRY_W-1:ADV_W], a);
    end
    // Spaces that would overflow are dropped and the line broken instead
    if (32'(lx) + space_w <= 32'(cf_len)) begin
      foreach (space_buf[i]) place_glyph(space_buf[i][ENTRY_W-1:ADV_W], space_buf[i][ADV_W-1:0]);
    end else begin
      break_line();
    end
    word_buf.delete();
    space_buf.delete();
    word_w = 0;
    space_w = 0;
  endfunction

  function automatic void lay_out_char(input char_item_t it);
    step_out.delete();
    if (it.eot) begin
      flush_group();
      lx = '0;
      lidx = '0;
    end else if (!cf_multi) begin
      // Single line: every code is placed, buffers are left alone
      place_glyph(it.handle, it.adv);
      step_out[step_out.size()-1].y = '0;
    end else if (it.code == CH_NEWLINE) begin
      flush_group();
      break_line();
    end else if (it.code == CH_SPACE) begin
      if (space_buf.size() >= SPACE_MAX) begin
        space_full_flushes++;
        flush_group();
      end
      space_buf.push_back({it.handle, it.adv});
      space_w += 32'(it.adv);
    end else begin
      if (space_buf.size() == 0 && word_buf.size() >= WORD_MAX) word_full_flushes++;
      if (space_buf.size() > 0 || word_buf.size() >= WORD_MAX) flush_group();
      word_buf.push_back({it.handle, it.adv});
      word_w += 32'(it.adv);
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: check placements, predict on accepted items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    placement_t want;
    placement_t tp;
    char_item_t it;
    logic [GLYPH_W-1:0] g;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        g = m_tdata[GLYPH_W-1:0];
        x = m_tdata[GLYPH_W+X_W-1:GLYPH_W];
        y = m_tdata[GLYPH_W+X_W+Y_W-1:GLYPH_W+X_W];
        if (placements_due.size() == 0) begin
          report_mismatch($sformatf("unexpected placement glyph %0d x %0d y %0d", g, x, y));
        end else begin
          want = placements_due.pop_front();
          if (g != want.glyph)
            report_mismatch($sformatf("glyph is %0d, expected %0d", g, want.glyph));
          if (x != want.x)
            report_mismatch($sformatf("x is %0d, expected %0d", x, want.x));
          if (y != want.y)
            report_mismatch($sformatf("y is %0d, expected %0d", y, want.y));
          if (m_tlast != want.last)
            report_mismatch($sformatf("last is %0b, expected %0b", m_tlast, want.last));
        end
        n_placed++;
      end
      if (s_tvalid && s_tready) begin
        it = text_q.pop_front();
        s_busy = 1'b0;
        n_items++;
        lay_out_char(it);
        if (it.typed) begin
          // Directed row with its placement typed in; the predictor still advances
          tp.glyph = it.handle;
          tp.x = it.typed_x;
          tp.y = '0;
          tp.last = 1'b1;
          placements_due.push_back(tp);
        end else begin
          foreach (step_out[i]) placements_due.push_back(step_out[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: change inputs at the falling edge
  // ---------------------------------------------------------------------------
  // Slave side: hold an offered item until taken, idle only between items
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_busy) begin
      if (text_q.size() > 0 && $urandom_range(99, 0) >= s_idle_pct) begin
        s_tdata  <= IN_TDATA_W'({text_q[0].handle, text_q[0].adv, text_q[0].code});
        s_tlast  <= text_q[0].eot;
        s_tvalid <= 1'b1;
        s_busy = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Master side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off) begin
          @(negedge clk);
          held_total++;
        end
        hold_off = 0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= r_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic char_item_t make_char(input logic [CODE_W-1:0] code,
                                           input logic [ADV_W-1:0] adv,
                                           input logic [GLYPH_W-1:0] handle,
                                           input logic eot);
    char_item_t it;
    it.code = code;
    it.adv = adv;
    it.handle = handle;
    it.eot = eot;
    it.typed = 1'b0;
    it.typed_x = '0;
    return it;
  endfunction

  function automatic void chr_row(input logic [CODE_W-1:0] code, input logic [ADV_W-1:0] adv,
                                  input logic [GLYPH_W-1:0] handle, input logic eot,
                                  input bit typed, input logic [X_W-1:0] tx);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.val = '0;
    r.ch = make_char(code, adv, handle, eot);
    r.ch.typed = typed;
    r.ch.typed_x = tx;
    dir_tab.push_back(r);
  endfunction

  function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.ch = make_char('0, '0, '0, 1'b0);
    dir_tab.push_back(r);
  endfunction

  function automatic logic [ADV_W-1:0] rand_adv(input int cap);
    if ($urandom_range(3, 0) == 0) return ADV_W'($urandom_range(ADV_MAX, 0));
    return ADV_W'($urandom_range(cap, 0));
  endfunction

  // Any code point that belongs in a word
  function automatic logic [CODE_W-1:0] rand_word_code();
    logic [CODE_W-1:0] c;
    c = CODE_W'($urandom_range(1114111, 0));
    if (c == CH_NEWLINE || c == CH_SPACE) c = CODE_W'(8'h41);
    return c;
  endfunction

  function automatic void send(input logic [CODE_W-1:0] code, input int cap, input logic eot);
    text_q.push_back(make_char(code, rand_adv(cap), GLYPH_W'($urandom_range(65535, 0)), eot));
  endfunction

  // Well-formed text (words with trailing spaces, newlines, end of text) with
  // some noise; now and then a word or a run of spaces overfills its buffer
  function automatic void random_text(input int n, input int cap);
    int made;
    int kind;
    int len;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99, 0);
      if (kind < 6) begin
        send(CODE_W'($urandom_range(1114111, 0)), cap, 1'b0);
        made++;
      end else if (kind < 12) begin
        send(CH_NEWLINE, cap, 1'b0);
        made++;
      end else if (kind < 16) begin
        send(CODE_W'($urandom_range(1114111, 0)), cap, 1'b1);
        made++;
      end else begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(WORD_MAX + 4, WORD_MAX - 2)
                                          : $urandom_range(8, 1);
        repeat (len) send(rand_word_code(), cap, 1'b0);
        made += len;
        len = ($urandom_range(11, 0) == 0) ? $urandom_range(SPACE_MAX + 3, SPACE_MAX - 2)
                                           : $urandom_range(3, 0);
        repeat (len) send(CH_SPACE, cap, 1'b0);
        made += len;
      end
    end
  endfunction

  // Wait until every item is taken and every placement has come, then let a
  // flush that places nothing finish
  task automatic wait_drained();
    while (text_q.size() > 0 || s_busy || placements_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WRAP_MODE:   cf_multi = val[0];
      REG_LINE_LENGTH: cf_len = val;
      REG_LINE_HEIGHT: cf_height = val[HEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input bit multi, input logic [X_W-1:0] len,
                           input logic [HEIGHT_W-1:0] height);
    wait_drained();
    write_reg(REG_WRAP_MODE, CFG_DATA_W'(multi));
    write_reg(REG_LINE_LENGTH, len);
    write_reg(REG_LINE_HEIGHT, CFG_DATA_W'(height));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int waited;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single line after reset: placements follow the running x on line zero,
    // newline and space included, advance extremes at both ends
    chr_row(CODE_W'(8'h41), ADV_W'(ADV_MAX), 16'hFFFF, 1'b0, 1'b1, 16'd0);
    chr_row(CODE_W'(1114111), ADV_W'(0), 16'h0000, 1'b0, 1'b1, 16'd4095);
    chr_row(CH_SPACE, ADV_W'(1), 16'h1234, 1'b0, 1'b1, 16'd4095);
    chr_row(CH_NEWLINE, ADV_W'(ADV_MAX), 16'h8001, 1'b0, 1'b1, 16'd4096);
    // End of text with nothing buffered places nothing and returns to the origin
    chr_row(CODE_W'(8'h78), ADV_W'(ADV_MAX), 16'hABCD, 1'b1, 1'b0, '0);
    // Multi-line: word that fits, word that moves to a new line
    cfg_row(REG_WRAP_MODE, CFG_DATA_W'(1));
    cfg_row(REG_LINE_LENGTH, 16'd300);
    cfg_row(REG_LINE_HEIGHT, 16'd16383);
    chr_row(CODE_W'(8'h48), ADV_W'(100), 16'd1, 1'b0, 1'b0, '0);
    chr_row(CODE_W'(8'h69), ADV_W'(100), 16'd2, 1'b0, 1'b0, '0);
    chr_row(CH_SPACE, ADV_W'(50), 16'd3, 1'b0, 1'b0, '0);
    chr_row(CODE_W'(8'h77), ADV_W'(150), 16'd4, 1'b0, 1'b0, '0);
    chr_row(CH_NEWLINE, ADV_W'(0), 16'd9, 1'b0, 1'b0, '0);
    // Glyphs wider than the line: broken per glyph, even at x zero
    chr_row(CODE_W'(8'h4D), ADV_W'(ADV_MAX), 16'd5, 1'b0, 1'b0, '0);
    chr_row(CODE_W'(8'h57), ADV_W'(ADV_MAX), 16'd6, 1'b0, 1'b0, '0);
    chr_row(CH_NEWLINE, ADV_W'(7), 16'd10, 1'b0, 1'b0, '0);
    // Buffered word survives a switch to single line, flushed by end of text
    chr_row(CODE_W'(8'h61), ADV_W'(10), 16'd7, 1'b0, 1'b0, '0);
    cfg_row(REG_WRAP_MODE, CFG_DATA_W'(0));
    chr_row(CODE_W'(8'h62), ADV_W'(20), 16'd8, 1'b0, 1'b0, '0);
    cfg_row(REG_LINE_LENGTH, 16'd0);
    cfg_row(REG_LINE_HEIGHT, 16'd0);
    chr_row(CODE_W'(8'h63), ADV_W'(0), 16'd11, 1'b1, 1'b0, '0);
    // Empty groups on a zero-length line
    cfg_row(REG_WRAP_MODE, CFG_DATA_W'(1));
    chr_row(CH_NEWLINE, ADV_W'(0), 16'd12, 1'b0, 1'b0, '0);
    chr_row(CH_NEWLINE, ADV_W'(ADV_MAX), 16'd13, 1'b0, 1'b0, '0);
    chr_row(CODE_W'(8'h7A), ADV_W'(0), 16'd14, 1'b1, 1'b0, '0);

    @(posedge clk);
    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        wait_drained();
        write_reg(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        text_q.push_back(dir_tab[r].ch);
      end
    end

    // Random text; sender idles lightly, receiver heavily
    configure(1'b1, 16'd2000, 14'd1024);
    random_text(80, 400);
    configure(1'b0, X_W'($urandom_range(65535, 0)), HEIGHT_W'($urandom_range(16383, 0)));
    random_text(60, ADV_MAX);    // long enough to clamp x

    // Roles swapped; hold the receiver off so the block backs up into its input
    s_idle_pct = 78;
    r_idle_pct = 14;
    configure(1'b1, 16'd65535, 14'd16383);
    hold_off = 400;
    random_text(60, ADV_MAX);
    configure(1'b1, 16'd0, 14'd0);
    random_text(30, 200);

    // Neither side idles
    s_idle_pct = 0;
    r_idle_pct = 0;
    configure(1'b1, X_W'($urandom_range(8000, 0)), HEIGHT_W'($urandom_range(16383, 0)));
    random_text(70, 600);
    // Short tail on full-height lines, closed by a newline and end of text
    configure(1'b1, 16'd65535, 14'd16383);
    random_text(12, 300);
    send(CH_NEWLINE, 0, 1'b0);
    send(CODE_W'(8'h2E), 0, 1'b1);

    // Drain, with a bound on the wait for the last placements
    while (text_q.size() > 0 || s_busy) @(posedge clk);
    waited = 0;
    while (placements_due.size() > 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (placements_due.size() > 0)
      report_mismatch($sformatf("%0d placements never arrived", placements_due.size()));

    $display("Laid out %0d characters into %0d placements; deepest line %0d, x clamped %0d times.",
             n_items, n_placed, deepest_line, x_clamps);
    $display("Early flushes: %0d on a full word, %0d on full spaces; receiver held %0d cycles.",
             word_full_flushes, space_full_flushes, held_total);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- greedy_word_wrap_glyph_layout.f -----
hdl/gwwgl_pkg.sv
hdl/gwwgl_out_stage.sv
hdl/greedy_word_wrap_glyph_layout.sv
sim/greedy_word_wrap_glyph_layout_tb.sv
